FILE: rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg: shared constants for the triangle face normal pipeline
// Default parameter values, normalized magnitude width and output width.
// ----------------------------------------------------------------------------
package tfn_pkg;

  // default vertex coordinate width (signed Q12.12)
  localparam int COORD_WIDTH_DEF      = 24;
  // default fraction bits of the unit vector
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  // magnitudes are aligned so the largest lies in [2^29, 2^30)
  localparam int MAG_W                = 30;
  // width of the normal ports
  localparam int OUT_W                = 16;

endpackage

FILE: rtl/tfn_unit_vec.sv
// ----------------------------------------------------------------------------
// tfn_unit_vec: pipelined 3-component vector normalizer
// Aligns magnitudes by a common shift, sums squares, takes an integer square
// root one bit per stage and divides one quotient bit per stage.
// ----------------------------------------------------------------------------
module tfn_unit_vec #(
  parameter int IN_W = 25,
  parameter int FRAC = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic                   in_deg,
  input  logic [2:0][IN_W-1:0]   in_c,
  output logic                   out_vld,
  output logic                   out_deg,
  output logic [2:0][FRAC+1:0]   out_n
);
  import tfn_pkg::*;

  localparam int NW    = (IN_W > MAG_W) ? IN_W : MAG_W;
  localparam int NSTEP = $clog2(NW);
  localparam int SQ_W  = 2 * MAG_W;
  localparam int RT_W  = MAG_W + 1;
  localparam int RM_W  = SQ_W + 3;
  localparam int ND_W  = MAG_W + FRAC + 1;
  localparam int Q_W   = FRAC + 1;

  typedef struct packed {
    logic                vld;
    logic                deg;
    logic [2:0]          neg;
    logic [NW-1:0]       orw;
    logic [2:0][NW-1:0]  m;
  } clz_t;

  typedef struct packed {
    logic                   vld;
    logic                   deg;
    logic [2:0]             neg;
    logic [2:0][MAG_W-1:0]  a;
  } base_t;

  typedef struct packed {
    base_t                  b;
    logic [2:0][SQ_W-1:0]   sq;
  } sq_t;

  typedef struct packed {
    base_t             b;
    logic [RM_W-1:0]   rem;
    logic [RT_W-1:0]   root;
  } rt_t;

  typedef struct packed {
    logic                  vld;
    logic                  deg;
    logic [2:0]            neg;
    logic [RT_W-1:0]       len;
    logic [2:0][ND_W-1:0]  rem;
    logic [2:0][Q_W-1:0]   q;
  } dv_t;

  logic [2:0][IN_W-1:0] abs_c;
  logic [2:0][NW-1:0]   mag;
  logic [2:0]           neg;

  clz_t clz_r [NSTEP+1];
  sq_t  sq_r;
  rt_t  rt_r  [RT_W+1];
  dv_t  dv_r  [Q_W+1];

  logic                 out_vld_r;
  logic                 out_deg_r;
  logic [2:0][FRAC+1:0] out_n_r;

  // magnitudes and signs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i]   = in_c[i][IN_W-1];
      abs_c[i] = neg[i] ? (~in_c[i] + IN_W'(1)) : in_c[i];
      mag[i]   = NW'(abs_c[i]);
    end
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clz_r[0].vld <= 1'b0;
    end else if (en) begin
      clz_r[0].vld <= in_vld;
      clz_r[0].deg <= in_deg || (in_c == '0);
      clz_r[0].neg <= neg;
      clz_r[0].orw <= mag[0] | mag[1] | mag[2];
      clz_r[0].m   <= mag;
    end
  end

  // leading-zero shift, one binary step per stage; the OR word tracks the max
  for (genvar k = 0; k < NSTEP; k++) begin : g_clz
    localparam int SH = 1 << (NSTEP - 1 - k);
    clz_t clz_nxt;
    always_comb begin
      clz_nxt = clz_r[k];
      if (clz_r[k].orw[NW-1 -: SH] == '0) begin
        clz_nxt.orw = clz_r[k].orw << SH;
        for (int i = 0; i < 3; i++) begin
          clz_nxt.m[i] = clz_r[k].m[i] << SH;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        clz_r[k+1].vld <= 1'b0;
      end else if (en) begin
        clz_r[k+1] <= clz_nxt;
      end
    end
  end

  // align top bit to bit 29 and square
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r.b.vld <= 1'b0;
    end else if (en) begin
      sq_r.b.vld <= clz_r[NSTEP].vld;
      sq_r.b.deg <= clz_r[NSTEP].deg;
      sq_r.b.neg <= clz_r[NSTEP].neg;
      for (int i = 0; i < 3; i++) begin
        sq_r.b.a[i] <= clz_r[NSTEP].m[i][NW-1 -: MAG_W];
        sq_r.sq[i]  <= clz_r[NSTEP].m[i][NW-1 -: MAG_W] *
                       clz_r[NSTEP].m[i][NW-1 -: MAG_W];
      end
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_r[0].b.vld <= 1'b0;
    end else if (en) begin
      rt_r[0].b    <= sq_r.b;
      rt_r[0].rem  <= RM_W'(sq_r.sq[0]) + RM_W'(sq_r.sq[1]) + RM_W'(sq_r.sq[2]);
      rt_r[0].root <= '0;
    end
  end

  // integer square root, one root bit per stage
  for (genvar j = 0; j < RT_W; j++) begin : g_sqrt
    localparam int BI = RT_W - 1 - j;
    logic [RM_W-1:0] trial;
    rt_t             rt_nxt;
    assign trial = (RM_W'(rt_r[j].root) << (BI + 1)) + (RM_W'(1) << (2 * BI));
    always_comb begin
      rt_nxt = rt_r[j];
      if (rt_r[j].rem >= trial) begin
        rt_nxt.rem      = rt_r[j].rem - trial;
        rt_nxt.root[BI] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_r[j+1].b.vld <= 1'b0;
      end else if (en) begin
        rt_r[j+1] <= rt_nxt;
      end
    end
  end

  // dividend with half the length added for rounding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0].vld <= 1'b0;
    end else if (en) begin
      dv_r[0].vld <= rt_r[RT_W].b.vld;
      dv_r[0].deg <= rt_r[RT_W].b.deg;
      dv_r[0].neg <= rt_r[RT_W].b.neg;
      dv_r[0].len <= rt_r[RT_W].root;
      dv_r[0].q   <= '0;
      for (int i = 0; i < 3; i++) begin
        dv_r[0].rem[i] <= (ND_W'(rt_r[RT_W].b.a[i]) << FRAC) +
                          ND_W'(rt_r[RT_W].root >> 1);
      end
    end
  end

  // restoring division, one quotient bit per stage, three lanes
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    localparam int BQ = Q_W - 1 - j;
    logic [ND_W-1:0] dsr;
    dv_t             dv_nxt;
    assign dsr = ND_W'(dv_r[j].len) << BQ;
    always_comb begin
      dv_nxt = dv_r[j];
      for (int i = 0; i < 3; i++) begin
        if (dv_r[j].rem[i] >= dsr) begin
          dv_nxt.rem[i]   = dv_r[j].rem[i] - dsr;
          dv_nxt.q[i][BQ] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1].vld <= 1'b0;
      end else if (en) begin
        dv_r[j+1] <= dv_nxt;
      end
    end
  end

  // apply signs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_r[Q_W].vld;
      out_deg_r <= dv_r[Q_W].deg;
      for (int i = 0; i < 3; i++) begin
        out_n_r[i] <= dv_r[Q_W].neg[i] ? ((FRAC+2)'(0) - (FRAC+2)'(dv_r[Q_W].q[i]))
                                       : (FRAC+2)'(dv_r[Q_W].q[i]);
      end
    end
  end

  assign out_vld = out_vld_r;
  assign out_deg = out_deg_r;
  assign out_n   = out_n_r;

endmodule

FILE: rtl/tfn_cross.sv
// ----------------------------------------------------------------------------
// tfn_cross: two-stage cross product of two unit edge vectors
// Six registered products, then registered differences.
// ----------------------------------------------------------------------------
module tfn_cross #(
  parameter int FRAC = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic                       in_deg,
  input  logic [2:0][FRAC+1:0]       in_a,
  input  logic [2:0][FRAC+1:0]       in_b,
  output logic                       out_vld,
  output logic                       out_deg,
  output logic [2:0][2*FRAC+2:0]     out_c
);
  import tfn_pkg::*;

  localparam int EW = FRAC + 2;
  localparam int PW = 2 * EW;
  localparam int CW = 2 * FRAC + 3;

  logic signed [EW-1:0] sa [3];
  logic signed [EW-1:0] sb [3];
  logic signed [PW-1:0] prod [6];

  logic                 prd_vld_r;
  logic                 prd_deg_r;
  logic signed [PW-1:0] prd_r [6];

  logic                 crs_vld_r;
  logic                 crs_deg_r;
  logic [2:0][CW-1:0]   crs_r;

  // signed views and products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sa[i] = $signed(in_a[i]);
      sb[i] = $signed(in_b[i]);
    end
    prod[0] = sa[1] * sb[2];
    prod[1] = sa[2] * sb[1];
    prod[2] = sa[2] * sb[0];
    prod[3] = sa[0] * sb[2];
    prod[4] = sa[0] * sb[1];
    prod[5] = sa[1] * sb[0];
  end

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prd_vld_r <= 1'b0;
    end else if (en) begin
      prd_vld_r <= in_vld;
      prd_deg_r <= in_deg;
      for (int k = 0; k < 6; k++) begin
        prd_r[k] <= prod[k];
      end
    end
  end

  // difference stage; magnitudes stay below 2^(2*FRAC+1)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crs_vld_r <= 1'b0;
    end else if (en) begin
      crs_vld_r <= prd_vld_r;
      crs_deg_r <= prd_deg_r;
      for (int i = 0; i < 3; i++) begin
        crs_r[i] <= CW'(prd_r[2*i] - prd_r[2*i+1]);
      end
    end
  end

  assign out_vld = crs_vld_r;
  assign out_deg = crs_deg_r;
  assign out_c   = crs_r;

endmodule

FILE: rtl/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal: unit surface normal of one triangle
// Edges, edge normalization, cross product and final normalization.
// ----------------------------------------------------------------------------
// Takes one triangle per cycle while not stalled and returns its unit normal
// in signed Q2.14 (NORMAL_FRAC_BITS fraction bits, sign-extended or cut to
// 16 bits on the ports). The pipeline passes through two normalizers in
// series, each with a one-bit-per-stage square root and a one-bit-per-stage
// divider. Edges are ab = v2 - v0 and ac = v1 - v0, the normal is ab x ac.
// A zero-length edge or cross product returns a zero vector with
// out_degenerate set. The whole pipeline holds while a result sits stalled
// on the output.
// ----------------------------------------------------------------------------
module triangle_face_normal #(
  parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       in_v0_x,
  input  logic signed [COORD_WIDTH-1:0]       in_v0_y,
  input  logic signed [COORD_WIDTH-1:0]       in_v0_z,
  input  logic signed [COORD_WIDTH-1:0]       in_v1_x,
  input  logic signed [COORD_WIDTH-1:0]       in_v1_y,
  input  logic signed [COORD_WIDTH-1:0]       in_v1_z,
  input  logic signed [COORD_WIDTH-1:0]       in_v2_x,
  input  logic signed [COORD_WIDTH-1:0]       in_v2_y,
  input  logic signed [COORD_WIDTH-1:0]       in_v2_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tfn_pkg::OUT_W-1:0]    out_normal_x,
  output logic signed [tfn_pkg::OUT_W-1:0]    out_normal_y,
  output logic signed [tfn_pkg::OUT_W-1:0]    out_normal_z,
  output logic                                out_degenerate
);
  import tfn_pkg::*;

  localparam int EW  = COORD_WIDTH + 1;
  localparam int NNW = NORMAL_FRAC_BITS + 2;
  localparam int CRW = 2 * NORMAL_FRAC_BITS + 3;

  logic en;

  logic               edge_vld_r;
  logic [2:0][EW-1:0] ab_r;
  logic [2:0][EW-1:0] ac_r;

  logic                ab_vld, ac_vld, ab_deg, ac_deg;
  logic [2:0][NNW-1:0] nab, nac;

  logic                cr_vld, cr_deg;
  logic [2:0][CRW-1:0] cr;

  logic                nrm_vld, nrm_deg;
  logic [2:0][NNW-1:0] nrm;
  logic [2:0][OUT_W-1:0] n16;

  logic                  out_valid_r;
  logic                  out_deg_r;
  logic [2:0][OUT_W-1:0] out_n_r;

  // global advance: hold everything while a result is stalled
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // edge vectors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_vld_r <= 1'b0;
    end else if (en) begin
      edge_vld_r <= in_valid;
      ab_r[0] <= EW'(in_v2_x) - EW'(in_v0_x);
      ab_r[1] <= EW'(in_v2_y) - EW'(in_v0_y);
      ab_r[2] <= EW'(in_v2_z) - EW'(in_v0_z);
      ac_r[0] <= EW'(in_v1_x) - EW'(in_v0_x);
      ac_r[1] <= EW'(in_v1_y) - EW'(in_v0_y);
      ac_r[2] <= EW'(in_v1_z) - EW'(in_v0_z);
    end
  end

  tfn_unit_vec #(.IN_W(EW), .FRAC(NORMAL_FRAC_BITS)) u_norm_ab (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(edge_vld_r), .in_deg(1'b0), .in_c(ab_r),
    .out_vld(ab_vld), .out_deg(ab_deg), .out_n(nab)
  );

  tfn_unit_vec #(.IN_W(EW), .FRAC(NORMAL_FRAC_BITS)) u_norm_ac (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(edge_vld_r), .in_deg(1'b0), .in_c(ac_r),
    .out_vld(ac_vld), .out_deg(ac_deg), .out_n(nac)
  );

  tfn_cross #(.FRAC(NORMAL_FRAC_BITS)) u_cross (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(ab_vld), .in_deg(ab_deg || ac_deg), .in_a(nab), .in_b(nac),
    .out_vld(cr_vld), .out_deg(cr_deg), .out_c(cr)
  );

  tfn_unit_vec #(.IN_W(CRW), .FRAC(NORMAL_FRAC_BITS)) u_norm_cr (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(cr_vld), .in_deg(cr_deg), .in_c(cr),
    .out_vld(nrm_vld), .out_deg(nrm_deg), .out_n(nrm)
  );

  // fit the normal to the port width
  for (genvar i = 0; i < 3; i++) begin : g_fit
    if (NNW >= OUT_W) begin : g_trunc
      assign n16[i] = nrm[i][OUT_W-1:0];
    end else begin : g_sext
      assign n16[i] = {{(OUT_W-NNW){nrm[i][NNW-1]}}, nrm[i]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= nrm_vld;
      out_deg_r   <= nrm_deg;
      for (int i = 0; i < 3; i++) begin
        out_n_r[i] <= nrm_deg ? '0 : n16[i];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_degenerate = out_deg_r;
  assign out_normal_x   = out_n_r[0];
  assign out_normal_y   = out_n_r[1];
  assign out_normal_z   = out_n_r[2];

  // both edge normalizers run in lockstep
  a_edge_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    ab_vld == ac_vld)
    else $error("edge normalizers out of step");

  // a transfer in always lands in the edge stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> edge_vld_r)
    else $error("accepted triangle dropped");

  // a degenerate result carries a zero vector
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0))
    else $error("degenerate result with nonzero normal");

endmodule
